### design/sdp_pkg.sv
`default_nettype none

package sdp_pkg;

   localparam int NumDigits        = 32;
   localparam int NumPersistDigits = 8;
   localparam int PersistLoad      = 35;
   localparam int SegsPerDigit     = 8;

   localparam int DigitAw    = $clog2(NumDigits);
   localparam int PersistAw  = $clog2(NumPersistDigits);
   localparam int NumCounters = NumPersistDigits * SegsPerDigit;

   localparam int CountW     = 6;
   localparam int IntervalW  = 11;
   localparam int StreamBaseW = 17;

   localparam logic [IntervalW-1:0] IntervalReset = 11'd1300;

   typedef enum logic [1:0] {
      OpTick   = 2'd0,
      OpWrite  = 2'd1,
      OpStream = 2'd2,
      OpRead   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PosMask   = 2'd0,
      PosHeader = 2'd1,
      PosData   = 2'd2
   } stream_pos_type;

   localparam logic KindRead   = 1'b0;
   localparam logic KindStream = 1'b1;

   typedef enum logic {
      StIdle = 1'b0,
      StExec = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  digit_select;
      logic [7:0]  segment_bits;
      logic [7:0]  segment_number;
      logic [15:0] display_base;
      logic [7:0]  mux_bank;
      logic [15:0] read_index;
      logic        last;
   } req_item_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] segments_reversed;
      logic [7:0] brightness;
      logic [3:0] bytes_consumed;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic exec;
   } sdp_cmd_type;

   typedef struct packed {
      logic has_result;
      logic out_free;
   } sdp_stat_type;

   typedef logic [7:0] bright_lut_type [2**CountW];

   function automatic bright_lut_type build_bright_lut();
      bright_lut_type lut;
      for (int i = 0; i < 2**CountW; i++) begin
         lut[i] = 8'((i * 255) / PersistLoad);
      end
      return lut;
   endfunction

   localparam bright_lut_type BrightLut = build_bright_lut();

   function automatic logic [7:0] reverse_byte(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### design/sdp_req_if.sv
`default_nettype none

interface sdp_req_if;
   import sdp_pkg::*;

   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  digit_select;
   logic [7:0]  segment_bits;
   logic [7:0]  segment_number;
   logic [15:0] display_base;
   logic [7:0]  mux_bank;
   logic [15:0] read_index;
   logic        last;

   modport source (
      output valid, op, digit_select, segment_bits, segment_number,
             display_base, mux_bank, read_index, last,
      input  ready
   );

   modport sink (
      input  valid, op, digit_select, segment_bits, segment_number,
             display_base, mux_bank, read_index, last,
      output ready
   );

endinterface

`default_nettype wire

### design/sdp_rsp_if.sv
`default_nettype none

interface sdp_rsp_if;
   import sdp_pkg::*;

   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] segments_reversed;
   logic [7:0] brightness;
   logic [3:0] bytes_consumed;

   modport source (
      output valid, result_kind, segments_reversed, brightness, bytes_consumed,
      input  ready
   );

   modport sink (
      input  valid, result_kind, segments_reversed, brightness, bytes_consumed,
      output ready
   );

endinterface

`default_nettype wire

### design/sdp_ctrl.sv
`default_nettype none

module sdp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire sdp_pkg::sdp_stat_type stat,
   output sdp_pkg::sdp_cmd_type       cmd
);
   import sdp_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StExec;
            end
         end
         StExec: begin
            // hold the transaction while the result register is still occupied
            if (!stat.has_result || stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   a_exec_only_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> $past(cmd.load) || $past(state_ff == StExec))
      else $error("exec without a loaded transaction");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StExec) |-> !req_ready && !cmd.load)
      else $error("load while a transaction is in progress");

   a_load_then_exec_state: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == StExec)
      else $error("load did not enter exec");

endmodule

`default_nettype wire

### design/sdp_dpath.sv
`default_nettype none

module sdp_dpath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic [10:0]             csr_write_data,
   input  wire sdp_pkg::req_item_type   req_item,
   input  wire sdp_pkg::sdp_cmd_type    cmd,
   output sdp_pkg::sdp_stat_type        stat,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output sdp_pkg::rsp_item_type        rsp_item
);
   import sdp_pkg::*;

   req_item_type            item_ff;
   logic [IntervalW-1:0]    refresh_interval_ff;
   logic [IntervalW-1:0]    refresh_count_ff, refresh_count_in;
   logic [7:0]              digit_segments_ff [NumDigits];
   logic [7:0]              digit_segments_in [NumDigits];
   logic [CountW-1:0]       persist_ff [NumCounters];
   logic [CountW-1:0]       persist_in [NumCounters];
   stream_pos_type          stream_position_ff, stream_position_in;
   logic [7:0]              stream_mask_ff, stream_mask_in;
   logic [3:0]              stream_segment_ff, stream_segment_in;
   logic [StreamBaseW-1:0]  stream_base_ff, stream_base_in;
   logic [3:0]              stream_count_ff, stream_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_item_ff, rsp_item_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_item;
      end
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_interval_ff <= IntervalReset;
      end else if (csr_write_enable) begin
         refresh_interval_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_count_ff   <= '0;
         stream_position_ff <= PosMask;
         stream_mask_ff     <= '0;
         stream_segment_ff  <= '0;
         stream_base_ff     <= '0;
         stream_count_ff    <= '0;
         rsp_valid_ff       <= 1'b0;
         for (int j = 0; j < NumDigits; j++) begin
            digit_segments_ff[j] <= '0;
         end
         for (int k = 0; k < NumCounters; k++) begin
            persist_ff[k] <= '0;
         end
      end else begin
         refresh_count_ff   <= refresh_count_in;
         stream_position_ff <= stream_position_in;
         stream_mask_ff     <= stream_mask_in;
         stream_segment_ff  <= stream_segment_in;
         stream_base_ff     <= stream_base_in;
         stream_count_ff    <= stream_count_in;
         rsp_valid_ff       <= rsp_valid_in;
         digit_segments_ff  <= digit_segments_in;
         persist_ff         <= persist_in;
      end
   end

   assign stat.has_result = (item_ff.op == OpRead) ||
                            ((item_ff.op == OpStream) && item_ff.last);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic [IntervalW-1:0]   next_count;
      logic                   found;
      logic [2:0]             seg;
      logic [StreamBaseW-1:0] diff;
      logic [3:0]             report;
      logic [7:0]             dig;
      logic [CountW-1:0]      mx;
      logic [7:0]             bright;

      refresh_count_in   = refresh_count_ff;
      digit_segments_in  = digit_segments_ff;
      persist_in         = persist_ff;
      stream_position_in = stream_position_ff;
      stream_mask_in     = stream_mask_ff;
      stream_segment_in  = stream_segment_ff;
      stream_base_in     = stream_base_ff;
      stream_count_in    = stream_count_ff;
      rsp_item_in        = rsp_item_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;

      next_count = refresh_count_ff + 11'd1;
      found      = 1'b0;
      seg        = '0;
      diff       = '0;
      report     = '0;
      dig        = '0;
      mx         = '0;
      bright     = '0;

      if (cmd.exec) begin
         case (item_ff.op)
            OpTick: begin
               if (next_count < refresh_interval_ff) begin
                  refresh_count_in = next_count;
               end else begin
                  refresh_count_in = '0;
                  // every lit counter decays at once; reaching zero blanks the segment
                  for (int d = 0; d < NumPersistDigits; d++) begin
                     for (int s = 0; s < SegsPerDigit; s++) begin
                        if (persist_ff[d*SegsPerDigit+s] != '0) begin
                           persist_in[d*SegsPerDigit+s] =
                              persist_ff[d*SegsPerDigit+s] - 6'd1;
                           if (persist_ff[d*SegsPerDigit+s] == 6'd1) begin
                              digit_segments_in[d][s] = 1'b0;
                           end
                        end
                     end
                  end
               end
            end
            OpWrite: begin
               if (item_ff.segment_number < 8'd8) begin
                  for (int d = 0; d < 8; d++) begin
                     if (item_ff.digit_select[d]) begin
                        digit_segments_in[d] = digit_segments_ff[d] | item_ff.segment_bits;
                        for (int s = 0; s < SegsPerDigit; s++) begin
                           if (item_ff.segment_number[2:0] == 3'(s)) begin
                              persist_in[d*SegsPerDigit+s] = CountW'(PersistLoad);
                           end
                        end
                     end
                  end
               end
            end
            OpStream: begin
               case (stream_position_ff)
                  PosMask: begin
                     stream_mask_in    = item_ff.segment_bits;
                     stream_base_in    = {1'b0, item_ff.display_base} +
                                         {6'd0, item_ff.mux_bank, 3'd0};
                     stream_segment_in = '0;
                     stream_count_in   = '0;
                     report            = '0;
                     if (!item_ff.last) begin
                        stream_position_in = PosHeader;
                     end
                  end
                  PosHeader: begin
                     stream_count_in    = 4'd2;
                     stream_position_in = PosData;
                     report             = 4'd2;
                  end
                  default: begin
                     // next segment at or after the cursor whose mask bit is set
                     for (int i = SegsPerDigit - 1; i >= 0; i--) begin
                        if ((4'(i) >= stream_segment_ff) && stream_mask_ff[7-i]) begin
                           found = 1'b1;
                           seg   = 3'(i);
                        end
                     end
                     if (found) begin
                        for (int j = 0; j < NumDigits; j++) begin
                           diff = StreamBaseW'(j) - stream_base_ff;
                           if ((stream_base_ff <= StreamBaseW'(j)) &&
                               (diff < StreamBaseW'(8))) begin
                              digit_segments_in[j][seg] = item_ff.segment_bits[diff[2:0]];
                           end
                        end
                        stream_segment_in = {1'b0, seg} + 4'd1;
                        stream_count_in   = stream_count_ff + 4'd1;
                     end else begin
                        stream_segment_in = 4'd8;
                     end
                     report = stream_count_in;
                  end
               endcase
               if (item_ff.last) begin
                  stream_position_in = PosMask;
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.result_kind       = KindStream;
                  rsp_item_in.segments_reversed = '0;
                  rsp_item_in.brightness        = '0;
                  rsp_item_in.bytes_consumed    = report;
               end
            end
            OpRead: begin
               if (item_ff.read_index < 16'(NumDigits)) begin
                  dig = digit_segments_ff[item_ff.read_index[DigitAw-1:0]];
                  if (dig != '0) begin
                     if (item_ff.read_index >= 16'(NumPersistDigits)) begin
                        bright = 8'd255;
                     end else begin
                        for (int s = 0; s < SegsPerDigit; s++) begin
                           if (persist_ff[{item_ff.read_index[PersistAw-1:0], 3'(s)}] > mx)
                           begin
                              mx = persist_ff[{item_ff.read_index[PersistAw-1:0], 3'(s)}];
                           end
                        end
                        bright = BrightLut[mx];
                     end
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_item_in.result_kind       = KindRead;
               rsp_item_in.segments_reversed = reverse_byte(dig);
               rsp_item_in.brightness        = bright;
               rsp_item_in.bytes_consumed    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && stat.has_result) |-> stat.out_free)
      else $error("result register overwritten before it was taken");

   a_segment_cursor_range: assert property (@(posedge clock) disable iff (reset)
      stream_segment_ff <= 4'd8)
      else $error("stream segment cursor out of range");

   a_stream_count_bound: assert property (@(posedge clock) disable iff (reset)
      (stream_position_ff == PosData) |-> (stream_count_ff >= 4'd2) &&
                                          (stream_count_ff <= 4'd10))
      else $error("stream byte count out of range");

endmodule

`default_nettype wire

### design/segment_display_persistence.sv
// Segment display store with per-segment persistence counters.
// req_chan carries one operation per transaction: tick, common-anode write,
// buffer stream byte or digit read. rsp_chan returns one transaction for a
// digit read and one for a buffer stream byte marked last; other operations
// return nothing. csr_write_enable/csr_write_data load the refresh interval,
// written by the user only while the block is idle; not enforced here.
// Each transaction is taken in the idle state and executed in StExec,
// where it may hold (see below); the two-state controller accepts a new
// transaction only after the previous one has executed. The request is
// registered on acceptance, and the result register is loaded as the
// transaction executes, so rsp valid comes from a register.
// The rsp register parts the two sides: the next transaction is accepted
// while a result waits. If a new transaction produces a result while the
// previous one has not been taken, execution holds until rsp_chan.ready.
// Reset (synchronous, active high) clears all digits, counters and stream
// state and sets the refresh interval to 1300.
`default_nettype none

module segment_display_persistence (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   csr_write_enable,
   input  wire logic [10:0] csr_write_data,
   sdp_req_if.sink     req_chan,
   sdp_rsp_if.source   rsp_chan
);
   import sdp_pkg::*;

   sdp_cmd_type  cmd;
   sdp_stat_type stat;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         req_ready;
   logic         rsp_valid;

   assign req_item.op             = op_type'(req_chan.op);
   assign req_item.digit_select   = req_chan.digit_select;
   assign req_item.segment_bits   = req_chan.segment_bits;
   assign req_item.segment_number = req_chan.segment_number;
   assign req_item.display_base   = req_chan.display_base;
   assign req_item.mux_bank       = req_chan.mux_bank;
   assign req_item.read_index     = req_chan.read_index;
   assign req_item.last           = req_chan.last;

   assign req_chan.ready = req_ready;

   sdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sdp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_item         (req_item),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_item         (rsp_item)
   );

   assign rsp_chan.valid             = rsp_valid;
   assign rsp_chan.result_kind       = rsp_item.result_kind;
   assign rsp_chan.segments_reversed = rsp_item.segments_reversed;
   assign rsp_chan.brightness        = rsp_item.brightness;
   assign rsp_chan.bytes_consumed    = rsp_item.bytes_consumed;

endmodule

`default_nettype wire
